/* rtl/bdf_pkg.sv */
// Shared types and constants for the direct form I biquad filter core.
// Used by bdf_history, bdf_datapath and biquad_df1_filter_core; no dependencies.
package bdf_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int COEF_BITS           = 32;
    localparam int COEF_FRAC_BITS_DEF  = 28;
    localparam int CHANNELS_DEF        = 2;
    localparam int CFG_IDX_BITS        = 3;
    localparam int CFG_DATA_BITS       = COEF_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2 = 3'd4;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;

    typedef struct packed {
        t_sample sample_in;
        logic    channel;
    } t_in_beat;

    typedef struct packed {
        t_sample sample_out;
        logic    saturated;
    } t_out_beat;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    // One channel's delay line: two past inputs and two past outputs.
    typedef struct packed {
        t_sample x1;
        t_sample x2;
        t_sample y1;
        t_sample y2;
    } t_hist;

endpackage

/* rtl/bdf_history.sv */
// Per-channel delay-line registers for the biquad filter core.
// Depends on bdf_pkg for the sample and history types.
module bdf_history #(
    parameter int CHANNELS = bdf_pkg::CHANNELS_DEF,
    parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CH_W-1:0]      i_ch,
    output bdf_pkg::t_hist       o_hist,
    input  logic                 i_we,
    input  bdf_pkg::t_sample     i_x,
    input  bdf_pkg::t_sample     i_y
);

    bdf_pkg::t_sample r_x1 [CHANNELS];
    bdf_pkg::t_sample r_x2 [CHANNELS];
    bdf_pkg::t_sample r_y1 [CHANNELS];
    bdf_pkg::t_sample r_y2 [CHANNELS];

    assign o_hist.x1 = r_x1[i_ch];
    assign o_hist.x2 = r_x2[i_ch];
    assign o_hist.y1 = r_y1[i_ch];
    assign o_hist.y2 = r_y2[i_ch];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else if (i_we) begin
            r_x2[i_ch] <= r_x1[i_ch];
            r_x1[i_ch] <= i_x;
            r_y2[i_ch] <= r_y1[i_ch];
            r_y1[i_ch] <= i_y;
        end
    end

endmodule

/* rtl/bdf_datapath.sv */
// Multiply-accumulate, rounding and saturation for one biquad output sample.
// Depends on bdf_pkg for the sample, coefficient and beat types.
module bdf_datapath #(
    parameter int COEF_FRAC_BITS = bdf_pkg::COEF_FRAC_BITS_DEF
) (
    input  bdf_pkg::t_sample   i_x,
    input  bdf_pkg::t_hist     i_hist,
    input  bdf_pkg::t_coefs    i_coefs,
    output bdf_pkg::t_out_beat o_result
);

    localparam int PROD_W = bdf_pkg::COEF_BITS + bdf_pkg::SAMPLE_BITS;
    // Five products plus the rounding bias never need more than three extra bits.
    localparam int ACC_W  = PROD_W + 3;
    localparam int SHR_W  = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

    logic signed [PROD_W-1:0] w_p_b0, w_p_b1, w_p_b2, w_p_a1, w_p_a2;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [SHR_W-1:0]  w_q;
    logic [SHR_W-bdf_pkg::SAMPLE_BITS:0] w_upper;
    logic                     w_fits;

    assign w_p_b0 = PROD_W'(i_coefs.b0) * PROD_W'(i_x);
    assign w_p_b1 = PROD_W'(i_coefs.b1) * PROD_W'(i_hist.x1);
    assign w_p_b2 = PROD_W'(i_coefs.b2) * PROD_W'(i_hist.x2);
    assign w_p_a1 = PROD_W'(i_coefs.a1) * PROD_W'(i_hist.y1);
    assign w_p_a2 = PROD_W'(i_coefs.a2) * PROD_W'(i_hist.y2);

    assign w_acc = ACC_W'(w_p_b0) + ACC_W'(w_p_b1) + ACC_W'(w_p_b2)
                 - ACC_W'(w_p_a1) - ACC_W'(w_p_a2) + ROUND_BIAS;

    // Arithmetic shift by the fraction width, then check that everything above
    // the sample's sign bit is a copy of it.
    assign w_q     = $signed(w_acc[ACC_W-1:COEF_FRAC_BITS]);
    assign w_upper = w_q[SHR_W-1:bdf_pkg::SAMPLE_BITS-1];
    assign w_fits  = (&w_upper) | ~(|w_upper);

    always_comb begin
        o_result.saturated = !w_fits;
        if (w_fits) begin
            o_result.sample_out = w_q[bdf_pkg::SAMPLE_BITS-1:0];
        end else if (w_q[SHR_W-1]) begin
            o_result.sample_out = bdf_pkg::SAMPLE_MIN;
        end else begin
            o_result.sample_out = bdf_pkg::SAMPLE_MAX;
        end
    end

endmodule

/* rtl/biquad_df1_filter_core.sv */
// Top level of the direct form I biquad filter: handshake, coefficient registers.
// Depends on bdf_pkg, bdf_history and bdf_datapath.
//
//   beat      | direction | signals
//   ----------+-----------+--------------------------------------------
//   sample in | input     | i_in_valid, o_in_ready, i_in_data
//   result    | output    | o_out_valid, i_out_ready, o_out_data
//   config    | input     | i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// Each sample beat is registered, then the five products, rounding and clip are
// computed combinationally into the result register, one beat per cycle sustained
// while the result is not stalled. The channel history is updated on that same
// edge, so a following beat on the same channel sees it without a bubble. Reset
// clears the history of every channel and loads the default coefficients. A stalled
// result holds the pipeline; the input register still takes a beat while it is empty.
module biquad_df1_filter_core #(
    parameter int CHANNELS       = bdf_pkg::CHANNELS_DEF,
    parameter int COEF_FRAC_BITS = bdf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bdf_pkg::t_in_beat                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bdf_pkg::t_out_beat                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [bdf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [bdf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam bdf_pkg::t_coef B0_RESET = bdf_pkg::COEF_BITS'(64'd1 << COEF_FRAC_BITS);

    logic               r_in_valid;
    bdf_pkg::t_in_beat  r_in;
    logic               r_out_valid;
    bdf_pkg::t_out_beat r_out;
    bdf_pkg::t_coefs    r_coefs;
    bdf_pkg::t_coefs    n_coefs;

    logic               w_adv;
    logic [CH_W-1:0]    w_ch;
    bdf_pkg::t_hist     w_hist;
    bdf_pkg::t_out_beat w_result;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A channel number beyond the last channel wraps around.
    assign w_ch = (CHANNELS > 1) ? CH_W'(r_in.channel) : '0;

    bdf_history #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ch    (w_ch),
        .o_hist  (w_hist),
        .i_we    (w_adv),
        .i_x     (r_in.sample_in),
        .i_y     (w_result.sample_out)
    );

    bdf_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_x      (r_in.sample_in),
        .i_hist   (w_hist),
        .i_coefs  (r_coefs),
        .o_result (w_result)
    );

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bdf_pkg::REG_COEF_B0: n_coefs.b0 = i_cfg_data;
                bdf_pkg::REG_COEF_B1: n_coefs.b1 = i_cfg_data;
                bdf_pkg::REG_COEF_B2: n_coefs.b2 = i_cfg_data;
                bdf_pkg::REG_COEF_A1: n_coefs.a1 = i_cfg_data;
                bdf_pkg::REG_COEF_A2: n_coefs.a2 = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_coefs.b0  <= B0_RESET;
            r_coefs.b1  <= '0;
            r_coefs.b2  <= '0;
            r_coefs.a1  <= '0;
            r_coefs.a2  <= '0;
        end else begin
            r_coefs <= n_coefs;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // A clipped result must sit exactly at one end of the sample range.
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            (o_out_data.sample_out == bdf_pkg::SAMPLE_MAX) ||
            (o_out_data.sample_out == bdf_pkg::SAMPLE_MIN))
        else $error("saturated result is not at a range limit");

    // With both registers full and the result stalled, no new beat may enter.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipeline is full and stalled");

    // A beat that moves to the result register is offered on the next cycle.
    a_adv_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("advanced beat did not reach the output");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for biquad_df1_filter_core: directed and random sample beats
// are checked against a cycle-free filter predictor kept inside this module.
// Depends on bdf_pkg and the RTL of the filter core.
module tb_top;
    import bdf_pkg::*;

    localparam int FRAC_BITS = COEF_FRAC_BITS_DEF;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_LAST = '1;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam t_coef COEF_ONE = t_coef'(1) <<< FRAC_BITS;
    localparam t_coef COEF_POS_MAX = 32'sh7fff_ffff;
    localparam t_coef COEF_NEG_MAX = 32'sh8000_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    t_in_beat                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    t_out_beat                out_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Predictor state: coefficients by register index and per-channel delay lines.
    t_coef     coef_regs [0:REG_COEF_A2];
    t_hist     chan_hist [0:CHANNELS_DEF-1];
    t_out_beat expected_q [$];
    int        mismatch_count;
    bit        tx_no_gap;
    bit        rx_no_stall;

    biquad_df1_filter_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // One filter step: exact wide sum, round half up, shift, clip, then shift history.
    function automatic t_out_beat filter_sample(t_in_beat beat);
        t_hist              h;
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        t_out_beat          res;
        h = chan_hist[beat.channel];
        acc = coef_regs[REG_COEF_B0] * beat.sample_in
            + coef_regs[REG_COEF_B1] * h.x1
            + coef_regs[REG_COEF_B2] * h.x2
            - coef_regs[REG_COEF_A1] * h.y1
            - coef_regs[REG_COEF_A2] * h.y2
            + ROUND_HALF;
        scaled = acc >>> FRAC_BITS;
        res.saturated = 1'b1;
        if (scaled > SAMPLE_MAX) begin
            res.sample_out = SAMPLE_MAX;
        end else if (scaled < SAMPLE_MIN) begin
            res.sample_out = SAMPLE_MIN;
        end else begin
            res.sample_out = scaled[SAMPLE_BITS-1:0];
            res.saturated  = 1'b0;
        end
        h.x2 = h.x1;
        h.x1 = beat.sample_in;
        h.y2 = h.y1;
        h.y1 = res.sample_out;
        chan_hist[beat.channel] = h;
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_sample(t_sample sample, logic channel);
        int       gap;
        t_in_beat beat;
        gap = tx_no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.sample_in = sample;
        beat.channel   = channel;
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(filter_sample(beat));
        if ($urandom_range(0, 31) == 0) tx_no_gap = !tx_no_gap;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, t_coef value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_COEF_A2) coef_regs[idx] = value;
        @(posedge clk);
    endtask

    task automatic write_coefs(t_coef b0, t_coef b1, t_coef b2, t_coef a1, t_coef a2);
        write_reg(REG_COEF_B0, b0);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // With the reset coefficients the section is a pass-through.
    task automatic test_reset_coefs();
        send_sample(t_sample'(0), 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(t_sample'(1), 1'b1);
        send_sample(t_sample'(-1), 1'b0);
    endtask

    // A gain of one half puts odd inputs exactly on the rounding midpoint.
    task automatic test_rounding();
        wait_for_idle();
        write_reg(REG_COEF_B0, COEF_ONE >>> 1);
        send_sample(t_sample'(1), 1'b1);
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(3), 1'b1);
        send_sample(t_sample'(-3), 1'b0);
    endtask

    task automatic test_saturation();
        wait_for_idle();
        write_reg(REG_COEF_B0, COEF_POS_MAX);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_for_idle();
        write_reg(REG_COEF_B0, COEF_NEG_MAX);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // All registers at their extremes; writes to unmapped indexes must change nothing.
    task automatic test_coef_extremes();
        wait_for_idle();
        write_coefs(COEF_NEG_MAX, COEF_POS_MAX, COEF_NEG_MAX, COEF_POS_MAX, COEF_NEG_MAX);
        for (int idx = int'(REG_COEF_A2) + 1; idx <= int'(CFG_IDX_LAST); idx++) begin
            write_reg(idx[CFG_IDX_BITS-1:0], t_coef'($urandom));
        end
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(-7), 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
    endtask

    // Stable low-pass with complex poles: impulse on one channel, step on the other.
    task automatic test_feedback();
        wait_for_idle();
        write_coefs(32'sh0200_0000, 32'sh0400_0000, 32'sh0200_0000,
                    -32'sh1800_0000, 32'sh0a00_0000);
        send_sample(t_sample'(24'sh40_0000), 1'b0);
        send_sample(t_sample'(24'sh20_0000), 1'b1);
        for (int i = 0; i < 3; i++) begin
            send_sample(t_sample'(0), 1'b0);
            send_sample(t_sample'(24'sh20_0000), 1'b1);
        end
    endtask

    task automatic test_random_phases();
        t_sample sample;
        for (int phase = 0; phase < 8; phase++) begin
            wait_for_idle();
            case (phase % 3)
                0: begin
                    // Coefficients within plus or minus one: mostly unclipped output.
                    write_coefs(t_coef'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000),
                                t_coef'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000),
                                t_coef'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000),
                                t_coef'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000),
                                t_coef'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000));
                end
                1: begin
                    write_coefs(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                                t_coef'($urandom), t_coef'($urandom));
                end
                default: begin
                    // Pure gain, no feedback.
                    write_coefs(t_coef'(int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000),
                                '0, '0, '0, '0);
                    write_reg(CFG_IDX_LAST, t_coef'($urandom));
                end
            endcase
            for (int i = 0; i < 50; i++) begin
                case ($urandom_range(0, 11))
                    0:       sample = SAMPLE_MAX;
                    1:       sample = SAMPLE_MIN;
                    2:       sample = '0;
                    default: sample = t_sample'($urandom);
                endcase
                send_sample(sample, 1'($urandom));
            end
        end
    endtask

    // Result side: random stalls, each accepted beat checked against the oldest prediction.
    initial begin
        int        stall;
        t_out_beat want;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: sample_out %0d saturated %0b",
                         $time, out_data.sample_out, out_data.saturated);
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                if (out_data.sample_out !== want.sample_out) begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want.sample_out, out_data.sample_out);
                    mismatch_count++;
                end
                if (out_data.saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $time, want.saturated, out_data.saturated);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 31) == 0) rx_no_stall = !rx_no_stall;
        end
    end

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        tx_no_gap      = 1'b0;
        rx_no_stall    = 1'b0;
        coef_regs[REG_COEF_B0] = COEF_ONE;
        coef_regs[REG_COEF_B1] = '0;
        coef_regs[REG_COEF_B2] = '0;
        coef_regs[REG_COEF_A1] = '0;
        coef_regs[REG_COEF_A2] = '0;
        for (int ch = 0; ch < CHANNELS_DEF; ch++) chan_hist[ch] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_rounding();
        test_saturation();
        test_coef_extremes();
        test_feedback();
        test_random_phases();

        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
